[rtl/core/ppu_pkg.sv]
// Package for the particle pool update block: types, widths, and the per-entry record.
// Used by the cell and the top level.
// No dependencies.
package ppu_pkg;

    localparam int unsigned DEPTH_DEF = 64;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // One stored particle.
    typedef struct packed {
        logic [47:0] pos;
        logic [47:0] vel;
        logic [47:0] acc;
        logic [15:0] life;
        logic [15:0] age;
        logic [31:0] scale;
        logic [31:0] rot;
        logic [31:0] c0;
        logic [31:0] c1;
    } t_part;

    // Input word.
    typedef struct packed {
        logic        mode;
        logic [15:0] life;
        logic [47:0] position;
        logic [47:0] velocity;
        logic [47:0] acceleration;
        logic [31:0] scale_pair;
        logic [31:0] rotation_pair;
        logic [31:0] start_color;
        logic [31:0] end_color;
    } t_in;

    // Output word.
    typedef struct packed {
        logic [47:0]        out_position;
        logic [15:0]        out_scale;
        logic signed [15:0] out_rotation;
        logic [31:0]        out_color;
        logic               last;
    } t_out;

    // Chain control, shared by every cell.
    typedef struct packed {
        logic ins;    // all cells take their left neighbor; head takes new word
        logic shl;    // all cells take their right-hand input (rotate)
    } t_ctl;

    // Saturating add of two signed Q8.8 values.
    function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
        logic signed [16:0] s;
        s = $signed({a[15], a}) + $signed({b[15], b});
        if (s > 17'sd32767)       sat_add = 16'h7FFF;
        else if (s < -17'sd32768) sat_add = 16'h8000;
        else                      sat_add = s[15:0];
    endfunction

endpackage

[rtl/core/ppu_if.sv]
// Valid/ready channel carrying one word of type T.
// No package dependencies; the payload type is the parameter T.
interface ppu_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/ppu_cell.sv]
// One entry of the particle chain: holds one particle and its live flag.
// Depends on ppu_pkg.
module ppu_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ppu_pkg::t_ctl  i_ctl,
    input  ppu_pkg::t_part i_left,
    input  logic           i_left_v,
    input  ppu_pkg::t_part i_right,
    input  logic           i_right_v,
    input  logic           i_wr,
    input  ppu_pkg::t_part i_wdata,
    input  logic           i_wv,
    output ppu_pkg::t_part o_part,
    output logic           o_v
);
    ppu_pkg::t_part r_part;
    logic           r_v;

    // Shift in either direction or take a direct write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_wr) begin
            r_v <= i_wv;
        end else if (i_ctl.ins) begin
            r_v <= i_left_v;
        end else if (i_ctl.shl) begin
            r_v <= i_right_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_part <= i_wdata;
        end else if (i_ctl.ins) begin
            r_part <= i_left;
        end else if (i_ctl.shl) begin
            r_part <= i_right;
        end
    end

    assign o_part = r_part;
    assign o_v    = r_v;
endmodule

[rtl/core/ppu_div.sv]
// Restoring divider, one quotient bit per cycle: q = min((age << 16) / life, 65536).
// No package dependencies; life is nonzero when started.
module ppu_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_age,
    input  logic [15:0] i_life,
    output logic        o_done,
    output logic [16:0] o_frac
);
    logic [31:0] r_num;
    logic [16:0] r_rem;
    logic [15:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [17:0] w_try;
    logic [16:0] w_rsh;

    assign w_rsh = {r_rem[15:0], r_num[31]};
    assign w_try = {1'b0, w_rsh} - {2'b00, r_den};

    // 32 steps over the shifted numerator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd31) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {i_age, 16'h0000};
            r_rem <= '0;
            r_den <= i_life;
        end else if (r_busy) begin
            if (!w_try[17]) r_rem <= w_try[16:0];
            else            r_rem <= w_rsh;
            r_num <= {r_num[30:0], ~w_try[17]};
        end
    end

    // High during the last step; quotient valid from the next cycle.
    assign o_done = r_busy && (r_cnt == 6'd31);
    // Quotient readable once busy drops; saturate at one.
    assign o_frac = ((|r_num[31:17]) || (r_num[16] && (|r_num[15:0]))) ? 17'h10000
                                                                      : r_num[16:0];
endmodule

[rtl/core/ppu_lerp.sv]
// Interpolation of scale, rotation and color bytes by a Q1.16 fraction, rounded.
// No package dependencies. Result registered.
module ppu_lerp (
    input  logic        i_clk,
    input  logic        i_go,
    input  logic [16:0] i_frac,
    input  logic [31:0] i_scale,
    input  logic [31:0] i_rot,
    input  logic [31:0] i_c0,
    input  logic [31:0] i_c1,
    output logic [15:0] o_scale,
    output logic [15:0] o_rot,
    output logic [31:0] o_color
);
    // s + floor(((e-s)*f + 32768) / 65536) on 17-bit signed differences.
    function automatic logic [15:0] lerp16(input logic signed [17:0] s,
                                            input logic signed [17:0] e,
                                            input logic [16:0] f);
        logic signed [35:0] p;
        p = (e - s) * $signed({1'b0, f}) + 36'sd32768;
        lerp16 = 16'(s + 18'(p >>> 16));
    endfunction

    logic [15:0] w_sc;
    logic [15:0] w_ro;
    logic [31:0] w_co;

    always_comb begin
        w_sc = lerp16({2'b00, i_scale[15:0]}, {2'b00, i_scale[31:16]}, i_frac);
        w_ro = lerp16({{2{i_rot[15]}}, i_rot[15:0]}, {{2{i_rot[31]}}, i_rot[31:16]}, i_frac);
        for (int k = 0; k < 4; k++) begin
            w_co[8*k +: 8] = 8'(lerp16({10'd0, i_c0[8*k +: 8]}, {10'd0, i_c1[8*k +: 8]},
                                       i_frac));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            o_scale <= w_sc;
            o_rot   <= w_ro;
            o_color <= w_co;
        end
    end
endmodule

[rtl/core/particle_pool_update.sv]
// Particle pool: chain of POOL_DEPTH cells, live particles packed at cells 0..count-1.
// Add word: accepted while idle, input stays ready, no result.
// Tick word: a compaction pass with one step per stored particle, then for each
// live particle update, 32-step divide, lerp, output (held until taken), rotate.
// Input is ready again after the rotate that follows the last result.
// Reset (synchronous, active low) clears count and flags.
module particle_pool_update #(
    parameter int unsigned POOL_DEPTH = ppu_pkg::DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ppu_if.sink   in_ch,
    ppu_if.source out_ch
);
    localparam int CW = $clog2(POOL_DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CMP  = 7'b0000010,
        S_UPD  = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_LRP  = 7'b0010000,
        S_OUT  = 7'b0100000,
        S_ROT  = 7'b1000000
    } t_st;

    t_st            r_st;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic [CW-1:0]  r_cnt;
    logic [CW-1:0]  r_left;
    ppu_pkg::t_ctl  w_ctl;
    ppu_pkg::t_part w_p   [POOL_DEPTH];
    logic           w_v   [POOL_DEPTH];
    ppu_pkg::t_part w_new;
    ppu_pkg::t_part w_upd;
    logic           w_add;
    logic           w_keep;
    logic           w_last;
    logic [16:0]    w_frac;
    logic           w_ddone;
    logic [15:0]    w_lsc;
    logic [15:0]    w_lro;
    logic [31:0]    w_lco;
    logic           w_full;

    assign w_full = (r_count == CW'(POOL_DEPTH));

    always_comb begin
        w_new.pos   = in_ch.data.position;
        w_new.vel   = in_ch.data.velocity;
        w_new.acc   = in_ch.data.acceleration;
        w_new.life  = in_ch.data.life;
        w_new.age   = 16'd0;
        w_new.scale = in_ch.data.scale_pair;
        w_new.rot   = in_ch.data.rotation_pair;
        w_new.c0    = in_ch.data.start_color;
        w_new.c1    = in_ch.data.end_color;
    end

    // Head particle advanced one frame.
    always_comb begin
        w_upd     = w_p[0];
        w_upd.age = w_p[0].age + 16'd1;
        for (int k = 0; k < 3; k++) begin
            w_upd.vel[16*k +: 16] = ppu_pkg::sat_add(w_p[0].vel[16*k +: 16],
                                                     w_p[0].acc[16*k +: 16]);
            w_upd.pos[16*k +: 16] = ppu_pkg::sat_add(w_p[0].pos[16*k +: 16],
                                                     w_upd.vel[16*k +: 16]);
        end
    end

    assign in_ch.ready = (r_st == S_IDLE);
    assign w_add = (r_st == S_IDLE) && in_ch.valid && (in_ch.data.mode == ppu_pkg::MODE_ADD)
                   && !w_full;

    // Insert on add; rotate during compaction and after each emitted word.
    always_comb begin
        w_ctl     = '0;
        w_ctl.ins = w_add;
        w_ctl.shl = (r_st inside {S_CMP, S_ROT});
    end

    // Head moves to the end of the live run; dropped there when expired, during compaction.
    assign w_keep = w_v[0] && ((r_st == S_ROT) || (w_p[0].age < w_p[0].life));

    for (genvar g = 0; g < POOL_DEPTH; g++) begin : g_cell
        ppu_pkg::t_part w_l, w_r, w_wd;
        logic           w_lv, w_rv, w_wr;
        if (g == 0) begin : g_h
            assign w_l  = w_new;
            assign w_lv = 1'b1;
            assign w_wr = (r_st == S_UPD);
            assign w_wd = w_upd;
        end else begin : g_b
            assign w_l  = w_p[g-1];
            assign w_lv = w_v[g-1];
            assign w_wr = 1'b0;
            assign w_wd = w_p[g];
        end
        if (g == POOL_DEPTH - 1) begin : g_t
            assign w_r  = w_p[0];
            assign w_rv = w_v[g] && w_keep;
        end else begin : g_n
            // Last live cell takes the head; the others take their neighbor.
            assign w_r  = w_v[g+1] ? w_p[g+1] : w_p[0];
            assign w_rv = w_v[g+1] || (w_v[g] && w_keep);
        end
        ppu_cell u_cell (
            .i_clk, .i_rst_n, .i_ctl(w_ctl),
            .i_left(w_l), .i_left_v(w_lv), .i_right(w_r), .i_right_v(w_rv),
            .i_wr(w_wr), .i_wdata(w_wd), .i_wv(1'b1),
            .o_part(w_p[g]), .o_v(w_v[g])
        );
    end

    // Particle count: up on add, down on each dropped head.
    always_comb begin
        n_count = r_count;
        if (w_add) begin
            n_count = r_count + CW'(1);
        end else if (r_st == S_CMP && !w_keep) begin
            n_count = r_count - CW'(1);
        end
    end

    ppu_div u_div (
        .i_clk, .i_rst_n, .i_start(r_st == S_UPD), .i_age(w_upd.age),
        .i_life(w_p[0].life), .o_done(w_ddone), .o_frac(w_frac)
    );

    ppu_lerp u_lerp (
        .i_clk, .i_go(r_st == S_LRP), .i_frac(w_frac),
        .i_scale(w_p[0].scale), .i_rot(w_p[0].rot), .i_c0(w_p[0].c0), .i_c1(w_p[0].c1),
        .o_scale(w_lsc), .o_rot(w_lro), .o_color(w_lco)
    );

    // Sequencer: compaction pass over the stored entries, then the walk.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_count <= '0;
            r_cnt   <= '0;
            r_left  <= '0;
        end else begin
            r_count <= n_count;
            case (r_st)
                S_IDLE: begin
                    if (in_ch.valid && in_ch.data.mode == ppu_pkg::MODE_TICK
                        && r_count != '0) begin
                        r_st  <= S_CMP;
                        r_cnt <= r_count;
                    end
                end
                S_CMP: begin
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_left <= n_count;
                        r_st   <= (n_count == '0) ? S_IDLE : S_UPD;
                    end
                end
                S_UPD: begin
                    r_st <= S_DIV;
                end
                S_DIV: begin
                    if (w_ddone) r_st <= S_LRP;
                end
                S_LRP: begin
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    if (out_ch.ready) begin
                        r_left <= r_left - CW'(1);
                        r_st   <= S_ROT;
                    end
                end
                S_ROT: begin
                    r_st <= (r_left == '0) ? S_IDLE : S_UPD;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign w_last = (r_left == CW'(1));

    // Result word, held steady while waiting in S_OUT.
    always_comb begin
        out_ch.valid             = (r_st == S_OUT);
        out_ch.data.out_position = w_p[0].pos;
        out_ch.data.out_scale    = w_lsc;
        out_ch.data.out_rotation = w_lro;
        out_ch.data.out_color    = w_lco;
        out_ch.data.last         = w_last;
    end
endmodule
